/* rtl/core/fvm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-voice mixer package
// Shared constants, operation codes, controller states and the command and
// status structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fvm_pkg;

  localparam int unsigned SAMPLE_BYTES = 131072;
  localparam int unsigned ADDR_W       = $clog2(SAMPLE_BYTES);
  localparam int unsigned VOICES       = 4;
  localparam int unsigned VOICE_W      = 2;
  localparam int unsigned LEN_W        = ADDR_W + 1;
  localparam int unsigned STEP_W       = 20;
  localparam int unsigned FRAC_W       = 16;
  localparam int unsigned RATIO_W      = 16;
  localparam int unsigned PERIOD_W     = 12;
  localparam int unsigned VOL_W        = 7;
  localparam int unsigned ACC_W        = 20;
  localparam int unsigned DIV_W        = 24;
  localparam int unsigned DIV_CNT_W    = 5;
  localparam int unsigned MIX_SHIFT    = 3;

  localparam logic [RATIO_W-1:0]  CLOCK_RATIO_RESET = 16'd41179;
  localparam logic [PERIOD_W-1:0] MIN_PERIOD        = 12'd28;
  localparam logic [VOL_W-1:0]    MAX_VOLUME        = 7'd64;
  localparam logic [LEN_W-1:0]    MAX_LENGTH        = LEN_W'(SAMPLE_BYTES);
  localparam logic [LEN_W-1:0]    MIN_LOOP          = 18'd2;
  localparam logic [VOICE_W-1:0]  LAST_VOICE        = VOICE_W'(VOICES - 1);

  typedef enum logic [2:0] {
    OP_WRITE   = 3'd0,
    OP_REGION  = 3'd1,
    OP_PERIOD  = 3'd2,
    OP_VOLUME  = 3'd3,
    OP_TRIGGER = 3'd4,
    OP_FRAME   = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_F_READ,
    ST_F_MIX,
    ST_F_WRAP,
    ST_F_MOD,
    ST_F_OUT
  } state_e;

  typedef struct packed {
    logic               capture;
    logic [VOICE_W-1:0] voice;
    logic               mem_write;
    logic               set_region;
    logic               set_volume;
    logic               trigger;
    logic               div_start;
    logic               div_mod;
    logic               load_step;
    logic               clear_acc;
    logic               mem_read;
    logic               mix;
    logic               commit_adv;
    logic               commit_mod;
    logic               stop_voice;
    logic               load_out;
  } cmd_t;

  typedef struct packed {
    op_e                op;
    logic [VOICE_W-1:0] channel;
    logic               cur_active;
    logic               wrap;
    logic               loop_on;
    logic               div_busy;
    logic               div_done;
    logic               out_free;
  } sts_t;

  // Voices 0 and 3 of every group of four take the louder share on the left.
  function automatic logic is_left(input logic [VOICE_W-1:0] v);
    return (v[1:0] == 2'd0) || (v[1:0] == 2'd3);
  endfunction

  // Arithmetic shift right by three, then clip to sixteen signed bits.
  function automatic logic signed [15:0] sat_mix(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] sh;
    sh = a >>> MIX_SHIFT;
    if (sh > 20'sd32767) begin
      return 16'sh7fff;
    end else if (sh < -20'sd32768) begin
      return 16'sh8000;
    end
    return sh[15:0];
  endfunction

endpackage

/* rtl/core/fvm_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-voice mixer divider
// Restoring divider, one quotient bit per cycle, shared by the step
// calculation and the loop wrap remainder.
// ----------------------------------------------------------------------------
module fvm_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fvm_pkg::DIV_W-1:0]  dividend_i,
  input  logic [fvm_pkg::LEN_W-1:0]  divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [fvm_pkg::DIV_W-1:0]  quotient_o,
  output logic [fvm_pkg::LEN_W-1:0]  remainder_o
);
  import fvm_pkg::*;

  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [LEN_W-1:0]     rem_q, rem_d;
  logic [LEN_W-1:0]     dsr_q;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic [LEN_W:0]       trial;
  logic                 ge;

  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    ge    = trial >= {1'b0, dsr_q};
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DIV_W-2:0], ge};
      rem_d = ge ? LEN_W'(trial - {1'b0, dsr_q}) : trial[LEN_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

/* rtl/core/fvm_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-voice mixer datapath
// Sample memory, per-voice registers, mixing accumulators and the output
// register, all driven by commands from the controller.
// ----------------------------------------------------------------------------
module fvm_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [2:0]                   operation_i,
  input  logic [1:0]                   channel_i,
  input  logic [16:0]                  write_address_i,
  input  logic signed [7:0]            sample_byte_i,
  input  logic [16:0]                  voice_base_i,
  input  logic [17:0]                  sample_length_i,
  input  logic [16:0]                  loop_begin_i,
  input  logic [17:0]                  loop_length_i,
  input  logic [11:0]                  period_i,
  input  logic [6:0]                   volume_i,
  input  logic [16:0]                  start_offset_i,
  input  logic                         cfg_we_i,
  input  logic [15:0]                  cfg_wdata_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic signed [15:0]           left_sample_o,
  output logic signed [15:0]           right_sample_o,
  output logic [3:0]                   active_voices_o,
  input  fvm_pkg::cmd_t                cmd_i,
  output fvm_pkg::sts_t                sts_o
);
  import fvm_pkg::*;

  // Captured transaction.
  op_e                 op_q;
  logic [VOICE_W-1:0]  ch_q;
  logic [ADDR_W-1:0]   waddr_q, base_in_q, ls_in_q, off_q;
  logic [7:0]          byte_q;
  logic [LEN_W-1:0]    len_in_q, ll_in_q;
  logic [PERIOD_W-1:0] period_q;
  logic [VOL_W-1:0]    vol_in_q;

  logic [RATIO_W-1:0]  ratio_q;

  logic [7:0]          mem_q [SAMPLE_BYTES];
  logic [7:0]          mem_rd_q;

  logic [ADDR_W-1:0]   base_q  [VOICES];
  logic [LEN_W-1:0]    len_q   [VOICES];
  logic [ADDR_W-1:0]   ls_q    [VOICES];
  logic [LEN_W-1:0]    ll_q    [VOICES];
  logic [VOL_W-1:0]    vol_q   [VOICES];
  logic [LEN_W-1:0]    pos_q   [VOICES];
  logic [FRAC_W-1:0]   frac_q  [VOICES];
  logic [STEP_W-1:0]   step_q  [VOICES];
  logic [VOICES-1:0]   active_q;
  logic [VOICES-1:0]   valid_q;

  logic [LEN_W-1:0]        adv_pos_q;
  logic signed [ACC_W-1:0] acc_l_q, acc_r_q;
  logic                    out_valid_q;
  logic signed [15:0]      left_q, right_q;
  logic [3:0]              mask_q;

  logic [VOICE_W-1:0] v;
  logic [LEN_W-1:0]   reg_len, reg_ll;
  logic [LEN_W:0]     reg_end, loop_end;
  logic [ADDR_W-1:0]  rd_addr;
  logic [FRAC_W+4:0]  frac_sum;
  logic [LEN_W-1:0]   adv_pos;
  logic signed [15:0] prod;
  logic signed [ACC_W-1:0] prod_x, prod3;
  logic [PERIOD_W-1:0] per_clamped;
  logic [DIV_W-1:0]   div_dividend;
  logic [LEN_W-1:0]   div_divisor;
  logic               div_busy, div_done;
  logic [DIV_W-1:0]   div_quo;
  logic [LEN_W-1:0]   div_rem;

  assign v = cmd_i.voice;

  // Region sanitising: long lengths saturate, short or misplaced loops vanish
  // and a loop that runs past the end is clipped to it.
  always_comb begin
    reg_len = (len_in_q > MAX_LENGTH) ? MAX_LENGTH : len_in_q;
    reg_end = {2'b00, ls_in_q} + {1'b0, ll_in_q};
    if (ll_in_q <= MIN_LOOP || {1'b0, ls_in_q} >= reg_len) begin
      reg_ll = '0;
    end else if (reg_end > {1'b0, reg_len}) begin
      reg_ll = reg_len - {1'b0, ls_in_q};
    end else begin
      reg_ll = ll_in_q;
    end
  end

  always_comb begin
    rd_addr  = ADDR_W'(base_q[v] + pos_q[v][ADDR_W-1:0]);
    frac_sum = {5'd0, frac_q[v]} + {1'b0, step_q[v]};
    adv_pos  = pos_q[v] + LEN_W'(frac_sum[FRAC_W+4:FRAC_W]);
    prod     = 16'($signed(mem_rd_q)) * 16'($signed({1'b0, vol_q[v]}));
    prod_x   = ACC_W'(prod);
    prod3    = (prod_x <<< 1) + prod_x;
    loop_end = {2'b00, ls_q[v]} + {1'b0, ll_q[v]};
    per_clamped = (period_q < MIN_PERIOD) ? MIN_PERIOD : period_q;
    if (cmd_i.div_mod) begin
      div_dividend = DIV_W'(adv_pos_q - {1'b0, ls_q[v]});
      div_divisor  = ll_q[v];
    end else begin
      div_dividend = {ratio_q, 8'd0};
      div_divisor  = LEN_W'(per_clamped);
    end
  end

  fvm_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= op_e'(operation_i);
      ch_q      <= channel_i;
      waddr_q   <= write_address_i;
      byte_q    <= sample_byte_i;
      base_in_q <= voice_base_i;
      len_in_q  <= sample_length_i;
      ls_in_q   <= loop_begin_i;
      ll_in_q   <= loop_length_i;
      period_q  <= period_i;
      vol_in_q  <= volume_i;
      off_q     <= start_offset_i;
    end
    if (cmd_i.mem_write) begin
      mem_q[waddr_q] <= byte_q;
    end
    if (cmd_i.mem_read) begin
      mem_rd_q <= mem_q[rd_addr];
    end
    if (cmd_i.mix) begin
      adv_pos_q <= adv_pos;
    end
    if (cmd_i.load_out) begin
      left_q  <= sat_mix(acc_l_q);
      right_q <= sat_mix(acc_r_q);
      mask_q  <= active_q[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q     <= CLOCK_RATIO_RESET;
      active_q    <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      acc_l_q     <= '0;
      acc_r_q     <= '0;
      for (int i = 0; i < VOICES; i++) begin
        base_q[i] <= '0;
        len_q[i]  <= '0;
        ls_q[i]   <= '0;
        ll_q[i]   <= '0;
        vol_q[i]  <= '0;
        pos_q[i]  <= '0;
        frac_q[i] <= '0;
        step_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        ratio_q <= cfg_wdata_i;
      end
      if (cmd_i.set_region) begin
        base_q[v]   <= base_in_q;
        len_q[v]    <= reg_len;
        ls_q[v]     <= ls_in_q;
        ll_q[v]     <= reg_ll;
        valid_q[v]  <= 1'b1;
        active_q[v] <= 1'b0;
      end
      if (cmd_i.set_volume) begin
        vol_q[v] <= (vol_in_q > MAX_VOLUME) ? MAX_VOLUME : vol_in_q;
      end
      if (cmd_i.trigger) begin
        pos_q[v]    <= {1'b0, off_q};
        frac_q[v]   <= '0;
        active_q[v] <= valid_q[v] && ({1'b0, off_q} < len_q[v]);
      end
      if (cmd_i.load_step) begin
        step_q[v] <= div_quo[STEP_W-1:0];
      end
      if (cmd_i.clear_acc) begin
        acc_l_q <= '0;
        acc_r_q <= '0;
      end
      if (cmd_i.mix) begin
        frac_q[v] <= frac_sum[FRAC_W-1:0];
        if (is_left(v)) begin
          acc_l_q <= acc_l_q + prod3;
          acc_r_q <= acc_r_q + prod_x;
        end else begin
          acc_l_q <= acc_l_q + prod_x;
          acc_r_q <= acc_r_q + prod3;
        end
      end
      if (cmd_i.commit_adv) begin
        pos_q[v] <= adv_pos_q;
      end
      if (cmd_i.commit_mod) begin
        pos_q[v] <= {1'b0, ls_q[v]} + div_rem;
      end
      if (cmd_i.stop_voice) begin
        active_q[v] <= 1'b0;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.op         = op_q;
    sts_o.channel    = ch_q;
    sts_o.cur_active = active_q[v] && valid_q[v] && (len_q[v] != '0);
    sts_o.wrap       = (adv_pos_q >= len_q[v]) ||
                       ((ll_q[v] != '0) && ({1'b0, adv_pos_q} >= loop_end));
    sts_o.loop_on    = ll_q[v] != '0;
    sts_o.div_busy   = div_busy;
    sts_o.div_done   = div_done;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o     = out_valid_q;
  assign left_sample_o   = left_q;
  assign right_sample_o  = right_q;
  assign active_voices_o = mask_q;

endmodule

/* rtl/core/fvm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-voice mixer controller
// State machine that decodes each transaction and sequences the frame
// through the voices one at a time.
// ----------------------------------------------------------------------------
module fvm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fvm_pkg::sts_t sts_i,
  output fvm_pkg::cmd_t cmd_o
);
  import fvm_pkg::*;

  state_e state_q, state_d;
  logic [VOICE_W-1:0] vidx_q, vidx_d;
  logic voice_done;

  // A voice is finished when its position is written back, or at once if it is idle.
  always_comb begin
    voice_done = 1'b0;
    unique case (state_q)
      ST_F_READ: voice_done = !sts_i.cur_active;
      ST_F_WRAP: voice_done = !(sts_i.wrap && sts_i.loop_on);
      ST_F_MOD:  voice_done = sts_i.div_done;
      default:   voice_done = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    vidx_d  = vidx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (sts_i.op)
          OP_PERIOD: state_d = ST_DIV;
          OP_FRAME: begin
            state_d = ST_F_READ;
            vidx_d  = '0;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_IDLE;
      end
      ST_F_READ: begin
        if (sts_i.cur_active) state_d = ST_F_MIX;
      end
      ST_F_MIX: state_d = ST_F_WRAP;
      ST_F_WRAP: begin
        if (sts_i.wrap && sts_i.loop_on) state_d = ST_F_MOD;
      end
      ST_F_MOD: ;
      ST_F_OUT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (voice_done) begin
      if (vidx_q == LAST_VOICE) begin
        state_d = ST_F_OUT;
      end else begin
        state_d = ST_F_READ;
        vidx_d  = vidx_q + 1'b1;
      end
    end
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    cmd_o.voice = sts_i.channel;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_DECODE: begin
        unique case (sts_i.op)
          OP_WRITE:   cmd_o.mem_write  = 1'b1;
          OP_REGION:  cmd_o.set_region = 1'b1;
          OP_PERIOD:  cmd_o.div_start  = 1'b1;
          OP_VOLUME:  cmd_o.set_volume = 1'b1;
          OP_TRIGGER: cmd_o.trigger    = 1'b1;
          OP_FRAME:   cmd_o.clear_acc  = 1'b1;
          default: ;
        endcase
      end
      ST_DIV: cmd_o.load_step = sts_i.div_done;
      ST_F_READ: begin
        cmd_o.voice    = vidx_q;
        cmd_o.mem_read = sts_i.cur_active;
      end
      ST_F_MIX: begin
        cmd_o.voice = vidx_q;
        cmd_o.mix   = 1'b1;
      end
      ST_F_WRAP: begin
        cmd_o.voice = vidx_q;
        if (!sts_i.wrap) begin
          cmd_o.commit_adv = 1'b1;
        end else if (sts_i.loop_on) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_mod   = 1'b1;
        end else begin
          cmd_o.commit_adv = 1'b1;
          cmd_o.stop_voice = 1'b1;
        end
      end
      ST_F_MOD: begin
        cmd_o.voice      = vidx_q;
        cmd_o.div_mod    = 1'b1;
        cmd_o.commit_mod = sts_i.div_done;
      end
      ST_F_OUT: cmd_o.load_out = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vidx_q  <= '0;
    end else begin
      state_q <= state_d;
      vidx_q  <= vidx_d;
    end
  end

  // The output register is only loaded when its previous frame has gone.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> sts_i.out_free) else $error("output overwritten");

  // The divider is never restarted while it is still working.
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !sts_i.div_busy) else $error("divider restarted");

  // A memory read is followed by the mix of the same voice.
  a_read_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mem_read |=> (cmd_o.mix && cmd_o.voice == $past(cmd_o.voice)))
    else $error("read not followed by mix");

endmodule

/* rtl/core/four_voice_sample_mixer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-voice sample mixer
// Wavetable playback of four voices from a byte-wide sample memory, mixed
// into one stereo frame per frame transaction.
// ----------------------------------------------------------------------------
// Usage. Commands arrive on the input channel (in_valid_i / in_ready_o); each
// transaction carries an operation code and all fields, of which only those
// that the operation needs are used. Only the frame operation produces a
// transaction on the output channel (out_valid_o / out_ready_i).
// Sequencing. A transaction is accepted in the idle state and then decoded; byte
// writes, region, volume and trigger operations then return to idle for the
// next transaction. Setting a period runs the shared 24-step restoring
// divider. A frame visits the voices in turn: an idle voice moves straight on, a
// playing voice passes through memory read, mix and position update, and
// through the same divider as well when its position wraps into a loop.
// Reset clears all voice registers and stops every voice; clock_ratio
// returns to 41179. The sample memory is not cleared.
// Stalls. A finished frame sits in the output register while new commands
// are accepted; the next frame waits at its end until that slot is taken.
// ----------------------------------------------------------------------------
module four_voice_sample_mixer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         operation_i,
  input  logic [1:0]         channel_i,
  input  logic [16:0]        write_address_i,
  input  logic signed [7:0]  sample_byte_i,
  input  logic [16:0]        voice_base_i,
  input  logic [17:0]        sample_length_i,
  input  logic [16:0]        loop_begin_i,
  input  logic [17:0]        loop_length_i,
  input  logic [11:0]        period_i,
  input  logic [6:0]         volume_i,
  input  logic [16:0]        start_offset_i,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] left_sample_o,
  output logic signed [15:0] right_sample_o,
  output logic [3:0]         active_voices_o
);
  import fvm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller only sequences; every value lives in the datapath.
  fvm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fvm_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .operation_i     (operation_i),
    .channel_i       (channel_i),
    .write_address_i (write_address_i),
    .sample_byte_i   (sample_byte_i),
    .voice_base_i    (voice_base_i),
    .sample_length_i (sample_length_i),
    .loop_begin_i    (loop_begin_i),
    .loop_length_i   (loop_length_i),
    .period_i        (period_i),
    .volume_i        (volume_i),
    .start_offset_i  (start_offset_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .left_sample_o   (left_sample_o),
    .right_sample_o  (right_sample_o),
    .active_voices_o (active_voices_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-voice sample mixer regression
// Drives directed and random command traffic, including region, period,
// volume, trigger and frame commands under several clock ratios. It predicts
// every stereo frame from its own model of the voices and compares the mixer's
// output transactions against it, field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
  import fvm_pkg::*;

  // Codes that the mixer must ignore; they carry no operation.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int unsigned MEM_BYTES  = 131072;
  localparam int unsigned SETTLE     = 150;    // longest frame plus margin
  localparam int unsigned STUCK_MAX  = 20000;  // cycles without any transaction

  typedef struct {
    logic [2:0]  op;
    logic [1:0]  channel;
    logic [16:0] address;
    logic [7:0]  sample;
    logic [16:0] base;
    logic [17:0] length;
    logic [16:0] rep_from;
    logic [17:0] rep_size;
    logic [11:0] period;
    logic [6:0]  volume;
    logic [16:0] offset;
  } mixer_cmd_t;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic [3:0]  active;
  } frame_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [2:0] operation_i;
  logic [1:0] channel_i;
  logic [16:0] write_address_i, voice_base_i, loop_begin_i, start_offset_i;
  logic signed [7:0] sample_byte_i;
  logic [17:0] sample_length_i, loop_length_i;
  logic [11:0] period_i;
  logic [6:0] volume_i;
  logic cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic signed [15:0] left_sample_o, right_sample_o;
  logic [3:0] active_voices_o;

  four_voice_sample_mixer dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .channel_i,
    .write_address_i, .sample_byte_i, .voice_base_i, .sample_length_i,
    .loop_begin_i, .loop_length_i, .period_i, .volume_i, .start_offset_i,
    .cfg_we_i, .cfg_wdata_i, .out_valid_o, .out_ready_i, .left_sample_o,
    .right_sample_o, .active_voices_o
  );

  // Shadow state of the mixer. The memory shadow also records which bytes
  // have been written, so that a frame never reads a byte nobody stored.
  logic [7:0]  mem_shadow [MEM_BYTES];
  bit          mem_written [MEM_BYTES];
  int unsigned ratio_shadow;
  int unsigned base_sh [4], len_sh [4], lstart_sh [4], llen_sh [4];
  int unsigned vol_sh [4], pos_sh [4], frac_sh [4], step_sh [4];
  bit          playing [4], region_ok [4];

  frame_t frames_due [$];
  int     errors;
  bit     calm;         // set for the final stretch: no idling on either side
  int     stuck_cycles;
  int     ready_hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The predictor proper: applies one accepted command to the shadow state
  // and, for a frame, queues the stereo result that the mixer must produce.
  task automatic predict_command(input mixer_cmd_t c);
    int unsigned len, ll, pos, addr;
    int signed   acc_l, acc_r, s, v;
    logic signed [31:0] sh;
    frame_t f;
    int ch;
    ch = int'(c.channel);
    case (c.op)
      OP_WRITE: begin
        mem_shadow[c.address]  = c.sample;
        mem_written[c.address] = 1'b1;
      end
      OP_REGION: begin
        len = (c.length > MEM_BYTES) ? MEM_BYTES : 32'(c.length);
        ll  = 32'(c.rep_size);
        if (ll <= 2 || 32'(c.rep_from) >= len) begin
          ll = 0;
        end else if (32'(c.rep_from) + ll > len) begin
          ll = len - 32'(c.rep_from);
        end
        base_sh[ch]   = 32'(c.base);
        len_sh[ch]    = len;
        lstart_sh[ch] = 32'(c.rep_from);
        llen_sh[ch]   = ll;
        region_ok[ch] = 1'b1;
        playing[ch]   = 1'b0;
      end
      OP_PERIOD: begin
        pos = (c.period < 28) ? 28 : 32'(c.period);
        step_sh[ch] = ((ratio_shadow << 8) / pos) & 32'hFFFFF;
      end
      OP_VOLUME: vol_sh[ch] = (c.volume > 64) ? 64 : 32'(c.volume);
      OP_TRIGGER: begin
        pos_sh[ch]  = 32'(c.offset);
        frac_sh[ch] = 0;
        playing[ch] = region_ok[ch] && (32'(c.offset) < len_sh[ch]);
      end
      OP_FRAME: begin
        acc_l = 0;
        acc_r = 0;
        for (int i = 0; i < 4; i++) begin
          if (playing[i] && region_ok[i] && len_sh[i] != 0) begin
            pos  = pos_sh[i];
            addr = (base_sh[i] + pos) % MEM_BYTES;
            s = int'($signed(mem_shadow[addr]));
            v = s * int'(vol_sh[i]);
            // Voices 0 and 3 are panned left, 1 and 2 right, three to one.
            if (i == 0 || i == 3) begin
              acc_l += 3 * v;
              acc_r += v;
            end else begin
              acc_r += 3 * v;
              acc_l += v;
            end
            frac_sh[i] += step_sh[i];
            pos += frac_sh[i] >> 16;
            frac_sh[i] &= 32'hFFFF;
            ll = llen_sh[i];
            if (pos >= len_sh[i] || (ll != 0 && pos >= lstart_sh[i] + ll)) begin
              if (ll != 0) begin
                pos = lstart_sh[i] + (pos - lstart_sh[i]) % ll;
              end else begin
                playing[i] = 1'b0;
              end
            end
            pos_sh[i] = pos & 32'h3FFFF;
          end
        end
        sh = acc_l >>> 3;
        f.left = (sh > 32767) ? 16'h7fff : (sh < -32768) ? 16'h8000 : sh[15:0];
        sh = acc_r >>> 3;
        f.right = (sh > 32767) ? 16'h7fff : (sh < -32768) ? 16'h8000 : sh[15:0];
        f.active = {playing[3], playing[2], playing[1], playing[0]};
        frames_due.push_back(f);
      end
      default: ;  // spare codes change nothing
    endcase
  endtask

  // Every field is random; callers override what the operation needs, so the
  // unused fields still toggle every bit.
  function automatic mixer_cmd_t random_cmd(input logic [2:0] op);
    mixer_cmd_t c;
    c.op       = op;
    c.channel  = 2'($urandom_range(0, 3));
    c.address  = 17'($urandom);
    c.sample   = 8'($urandom);
    c.base     = 17'($urandom);
    c.length   = 18'($urandom);
    c.rep_from = 17'($urandom);
    c.rep_size = 18'($urandom);
    c.period   = 12'($urandom);
    c.volume   = 7'($urandom);
    c.offset   = 17'($urandom);
    return c;
  endfunction

  // Presents one command and holds it until the mixer takes the transaction.
  // Valid is left high; a gap lowers it separately.
  task automatic send_raw(input mixer_cmd_t c);
    operation_i     <= c.op;
    channel_i       <= c.channel;
    write_address_i <= c.address;
    sample_byte_i   <= c.sample;
    voice_base_i    <= c.base;
    sample_length_i <= c.length;
    loop_begin_i    <= c.rep_from;
    loop_length_i   <= c.rep_size;
    period_i        <= c.period;
    volume_i        <= c.volume;
    start_offset_i  <= c.offset;
    in_valid_i      <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_command(c);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  // Before a frame, any byte that a playing voice is about to read and that
  // was never written is filled first, so no read of unknown memory occurs.
  task automatic send_cmd(input mixer_cmd_t c);
    mixer_cmd_t w;
    int unsigned addr;
    if (c.op == OP_FRAME) begin
      for (int i = 0; i < 4; i++) begin
        addr = (base_sh[i] + pos_sh[i]) % MEM_BYTES;
        if (playing[i] && region_ok[i] && len_sh[i] != 0 && !mem_written[addr]) begin
          w = random_cmd(OP_WRITE);
          w.address = 17'(addr);
          send_raw(w);
        end
      end
    end
    send_raw(c);
  endtask

  // Holds valid low and waits until every frame has come back and the mixer has
  // had time to finish any period division.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_ratio(input logic [15:0] r);
    wait_quiet();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    ratio_shadow = 32'(r);
    @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // Directed: field extremes, every operation, the spare codes and each of
  // the special cases (long length, loop sanitising, clamps, trigger repair,
  // address wrap across the top of memory).
  task automatic test_directed();
    mixer_cmd_t c;
    c = random_cmd(OP_WRITE);  c.address = 17'h1FFFF; c.sample = 8'h80; send_cmd(c);
    c = random_cmd(OP_WRITE);  c.address = 17'h0;     c.sample = 8'h7F; send_cmd(c);
    c = random_cmd(OP_WRITE);  c.address = 17'h1;     c.sample = 8'hC3; send_cmd(c);
    // Voice 0 straddles the top of memory and loops over most of its sample.
    c = random_cmd(OP_REGION); c.channel = 0; c.base = 17'h1FFFF; c.length = 18'd4;
    c.rep_from = 17'd1; c.rep_size = 18'd3; send_cmd(c);
    c = random_cmd(OP_PERIOD); c.channel = 0; c.period = 12'd0; send_cmd(c);
    c = random_cmd(OP_VOLUME); c.channel = 0; c.volume = 7'd127; send_cmd(c);
    c = random_cmd(OP_TRIGGER); c.channel = 0; c.offset = 17'd0; send_cmd(c);
    // Voice 1: length above the memory size saturates; loop too short.
    c = random_cmd(OP_REGION); c.channel = 1; c.base = 17'd0; c.length = 18'h3FFFF;
    c.rep_from = 17'd0; c.rep_size = 18'd2; send_cmd(c);
    c = random_cmd(OP_PERIOD); c.channel = 1; c.period = 12'hFFF; send_cmd(c);
    c = random_cmd(OP_VOLUME); c.channel = 1; c.volume = 7'd64; send_cmd(c);
    c = random_cmd(OP_TRIGGER); c.channel = 1; c.offset = 17'h1FFFF; send_cmd(c);
    // Voice 2: loop start at the length gives a one-shot.
    c = random_cmd(OP_REGION); c.channel = 2; c.base = 17'd100; c.length = 18'd5;
    c.rep_from = 17'd5; c.rep_size = 18'h3FFFF; send_cmd(c);
    c = random_cmd(OP_PERIOD); c.channel = 2; c.period = 12'd27; send_cmd(c);
    c = random_cmd(OP_VOLUME); c.channel = 2; c.volume = 7'd0; send_cmd(c);
    c = random_cmd(OP_TRIGGER); c.channel = 2; c.offset = 17'd9; send_cmd(c);
    // Voice 3: loop clipped at the end of the sample.
    c = random_cmd(OP_REGION); c.channel = 3; c.base = 17'd200; c.length = 18'd6;
    c.rep_from = 17'd2; c.rep_size = 18'd100; send_cmd(c);
    c = random_cmd(OP_PERIOD); c.channel = 3; c.period = 12'd28; send_cmd(c);
    c = random_cmd(OP_VOLUME); c.channel = 3; c.volume = 7'd65; send_cmd(c);
    c = random_cmd(OP_TRIGGER); c.channel = 3; c.offset = 17'd5; send_cmd(c);
    c = random_cmd(OP_SPARE_LO); send_cmd(c);
    c = random_cmd(OP_SPARE_HI); send_cmd(c);
    repeat (4) send_cmd(random_cmd(OP_FRAME));
  endtask

  // Random traffic. Most of it is a well-formed voice set-up followed by a
  // few frames; the rest is single random commands, spare codes included.
  task automatic test_random_traffic(input int count);
    mixer_cmd_t c;
    int sent, ch;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 3) != 0) begin
        ch = $urandom_range(0, 3);
        c = random_cmd(OP_REGION); c.channel = 2'(ch);
        if ($urandom_range(0, 9) == 0) begin
          c.length = 18'($urandom_range(0, 18'h3FFFF));
        end else begin
          c.length   = 18'($urandom_range(0, 48));
          c.rep_from = 17'($urandom_range(0, 48));
          c.rep_size = 18'($urandom_range(0, 50));
        end
        send_cmd(c);
        if ($urandom_range(0, 1) != 0) begin
          c = random_cmd(OP_PERIOD); c.channel = 2'(ch);
          if ($urandom_range(0, 1) != 0) c.period = 12'($urandom_range(0, 600));
          send_cmd(c);
        end
        c = random_cmd(OP_VOLUME); c.channel = 2'(ch); send_cmd(c);
        c = random_cmd(OP_TRIGGER); c.channel = 2'(ch);
        if ($urandom_range(0, 4) != 0) c.offset = 17'($urandom_range(0, 50));
        send_cmd(c);
        sent += 4;
        repeat ($urandom_range(1, 6)) begin
          send_cmd(random_cmd(OP_FRAME));
          sent++;
        end
      end else begin
        c = random_cmd(3'($urandom_range(0, 7)));
        if (c.op == OP_REGION) begin
          c.length = 18'($urandom_range(0, 64));
        end
        send_cmd(c);
        sent++;
      end
    end
  endtask

  // The sender stops until every expected frame has arrived, then resumes.
  task automatic test_drain_pause();
    test_random_traffic(60);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frames_due.size() != 0) @(posedge clk_i);
    test_random_traffic(60);
  endtask

  // Output side: compares each frame transaction with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frames_due.size() == 0) begin
        report_mismatch("unexpected frame, left_sample", int'(left_sample_o), 0);
      end else begin
        frame_t f;
        f = frames_due.pop_front();
        if (left_sample_o !== f.left)
          report_mismatch("left_sample", int'(left_sample_o), int'($signed(f.left)));
        if (right_sample_o !== f.right)
          report_mismatch("right_sample", int'(right_sample_o), int'($signed(f.right)));
        if (active_voices_o !== f.active)
          report_mismatch("active_voices", int'(active_voices_o), int'(f.active));
      end
    end
  end

  // Output back-pressure: random stall bursts.
  always @(posedge clk_i) begin
    if (calm) begin
      out_ready_i <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold  <= ready_hold - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      ready_hold  <= $urandom_range(0, 15);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog: ends the run if no transaction moves on either channel for far
  // longer than the slowest frame plus the longest stalls.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_MAX) begin
      $display("four_voice_sample_mixer regression: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    errors = 0; calm = 1'b0; stuck_cycles = 0; ready_hold = 0;
    rst_ni = 1'b0; in_valid_i = 1'b0; out_ready_i = 1'b0;
    operation_i = OP_WRITE; channel_i = '0; write_address_i = '0;
    sample_byte_i = '0; voice_base_i = '0; sample_length_i = '0;
    loop_begin_i = '0; loop_length_i = '0; period_i = '0; volume_i = '0;
    start_offset_i = '0; cfg_we_i = 1'b0; cfg_wdata_i = '0;
    ratio_shadow = 41179;
    for (int i = 0; i < 4; i++) begin
      base_sh[i] = 0; len_sh[i] = 0; lstart_sh[i] = 0; llen_sh[i] = 0;
      vol_sh[i] = 0; pos_sh[i] = 0; frac_sh[i] = 0; step_sh[i] = 0;
      playing[i] = 0; region_ok[i] = 0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic(200);          // reset clock ratio
    write_ratio(16'hFFFF);
    test_random_traffic(180);
    write_ratio(16'd1);
    test_random_traffic(120);
    write_ratio(16'($urandom_range(1, 16'hFFFF)));
    test_drain_pause();
    write_ratio(16'd41179);
    calm = 1'b1;
    test_random_traffic(200);

    wait_quiet();
    if (errors == 0) begin
      $display("four_voice_sample_mixer regression: pass");
    end else begin
      $display("four_voice_sample_mixer regression: fail");
    end
    $finish;
  end

endmodule
